[sv/sync_async_weighted_dispatcher_top_defines.svh]
// ----------------------------------------------------------------------------
// Dispatcher assertion macros
// Shared concurrent assertion forms for the dispatcher modules.
// ----------------------------------------------------------------------------
`ifndef SYNC_ASYNC_WEIGHTED_DISPATCHER_TOP_DEFINES_SVH
`define SYNC_ASYNC_WEIGHTED_DISPATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SAWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SAWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sawd_pkg.sv]
// ----------------------------------------------------------------------------
// sawd_pkg
// Types, codes and defaults shared by the weighted dispatcher modules.
// ----------------------------------------------------------------------------
package sawd_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TAG_WIDTH   = 16;

  localparam int PORT_TAG_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CNT_W      = 8;

  localparam logic [CNT_W-1:0] RESET_SYNC_QUOTA  = 8'd8;
  localparam logic [CNT_W-1:0] RESET_BATCH_LIMIT = 8'd4;

  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  localparam logic REG_SYNC_QUOTA  = 1'b0;
  localparam logic REG_BATCH_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_DROPPED    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] sync_quota;
    logic [CNT_W-1:0] batch_limit;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic at_head;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    status_t status;
    logic    from_sync;
  } res_t;

endpackage

[sv/sawd_if.sv]
// ----------------------------------------------------------------------------
// sawd_in_if / sawd_out_if
// Valid/ready channels for dispatcher requests and results.
// ----------------------------------------------------------------------------
interface sawd_in_if import sawd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PORT_TAG_W-1:0] request_tag;
  logic                  is_sync;
  logic                  at_head;

  modport source (output valid, action, request_tag, is_sync, at_head, input ready);
  modport sink   (input valid, action, request_tag, is_sync, at_head, output ready);
endinterface

interface sawd_out_if import sawd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [PORT_TAG_W-1:0] out_tag;
  logic                  out_sync;

  modport source (output valid, status, out_tag, out_sync, input ready);
  modport sink   (input valid, status, out_tag, out_sync, output ready);
endinterface

[sv/sawd_queue.sv]
// ----------------------------------------------------------------------------
// sawd_queue
// Circular deque of tags in a one-port-read synchronous memory.
// ----------------------------------------------------------------------------
`include "sync_async_weighted_dispatcher_top_defines.svh"

module sawd_queue import sawd_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_W = DEF_TAG_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_cmd_t           cmd,
  input  logic [TAG_W-1:0] wr_tag,
  output q_stat_t          stat,
  output logic [TAG_W-1:0] rd_tag
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rd_r;

  logic [IW-1:0] front_r, front_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  logic [IW-1:0] front_dec, front_inc, tail_idx, wr_idx;
  logic [SW-1:0] tail_sum;

  always_comb begin
    front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - IW'(1);
    front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + IW'(1);
    // front + fill stays below twice the depth: one compare and subtract
    tail_sum  = SW'(front_r) + SW'(fill_r);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail_idx  = tail_sum[IW-1:0];
    wr_idx    = cmd.at_head ? front_dec : tail_idx;
  end

  always_comb begin
    front_nxt = front_r;
    fill_nxt  = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + FW'(1);
      if (cmd.at_head) begin
        front_nxt = front_dec;
      end
    end else if (cmd.pop) begin
      fill_nxt  = fill_r - FW'(1);
      front_nxt = front_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx] <= wr_tag;
    end
    if (cmd.pop) begin
      rd_r <= mem[front_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      fill_r  <= '0;
    end else begin
      front_r <= front_nxt;
      fill_r  <= fill_nxt;
    end
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(DEPTH));
  assign rd_tag     = rd_r;

  `SAWD_ASSERT_NOW(a_no_pop_empty, cmd.pop, fill_r != '0, "pop from empty queue")
  `SAWD_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full && !cmd.pop, "push into full queue")
  `SAWD_ASSERT_NEXT(a_pop_count, cmd.pop, fill_r == $past(fill_r) - FW'(1), "pop count slip")

endmodule

[sv/sawd_sched.sv]
// ----------------------------------------------------------------------------
// sawd_sched
// Weighted round-robin choice between the sync and async queues.
// ----------------------------------------------------------------------------
module sawd_sched import sawd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  logic    action,
  input  logic    is_sync,
  input  logic    at_head,
  input  cfg_t    cfg,
  input  q_stat_t sync_stat,
  input  q_stat_t async_stat,
  output q_cmd_t  sync_cmd,
  output q_cmd_t  async_cmd,
  output res_t    res
);

  logic [CNT_W-1:0] batch_done_r, batch_done_nxt;
  logic [CNT_W-1:0] sync_served_r, sync_served_nxt;
  logic             async_due_r, async_due_nxt;

  logic             clr;
  logic [CNT_W-1:0] bd_base, ss_base, ss_inc;
  logic             due_base, tgt_full;

  always_comb begin
    clr      = (batch_done_r >= cfg.batch_limit);
    bd_base  = clr ? '0 : batch_done_r;
    ss_base  = clr ? '0 : sync_served_r;
    due_base = clr ? 1'b0 : async_due_r;
    ss_inc   = ss_base + CNT_W'(1);
    tgt_full = is_sync ? sync_stat.full : async_stat.full;
  end

  always_comb begin
    sync_cmd        = '0;
    async_cmd       = '0;
    res.status      = ST_INSERTED;
    res.from_sync   = 1'b0;
    batch_done_nxt  = batch_done_r;
    sync_served_nxt = sync_served_r;
    async_due_nxt   = async_due_r;
    if (fire) begin
      priority if (action == ACT_INSERT) begin
        if (tgt_full) begin
          res.status = ST_DROPPED;
        end else begin
          sync_cmd.push     = is_sync;
          async_cmd.push    = !is_sync;
          sync_cmd.at_head  = at_head;
          async_cmd.at_head = at_head;
        end
      end else if (sync_stat.empty && async_stat.empty) begin
        res.status      = ST_EMPTY;
        batch_done_nxt  = '0;
        sync_served_nxt = '0;
        async_due_nxt   = 1'b0;
      end else begin
        res.status = ST_DISPATCHED;
        // serve async when due, else sync, else fall back to async
        if ((due_base && !async_stat.empty) || sync_stat.empty) begin
          async_cmd.pop   = 1'b1;
          batch_done_nxt  = bd_base + CNT_W'(1);
          sync_served_nxt = '0;
          async_due_nxt   = 1'b0;
        end else begin
          sync_cmd.pop    = 1'b1;
          res.from_sync   = 1'b1;
          batch_done_nxt  = bd_base;
          sync_served_nxt = ss_inc;
          async_due_nxt   = (ss_inc >= cfg.sync_quota);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_done_r  <= '0;
      sync_served_r <= '0;
      async_due_r   <= 1'b0;
    end else begin
      batch_done_r  <= batch_done_nxt;
      sync_served_r <= sync_served_nxt;
      async_due_r   <= async_due_nxt;
    end
  end

endmodule

[sv/sawd_cfg.sv]
// ----------------------------------------------------------------------------
// sawd_cfg
// APB-style register file for the sync quota and the batch limit.
// ----------------------------------------------------------------------------
module sawd_cfg import sawd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CNT_W-1:0] sync_quota_r, sync_quota_nxt;
  logic [CNT_W-1:0] batch_limit_r, batch_limit_nxt;
  logic             wr_en;
  logic             reg_sel;
  logic [CNT_W-1:0] wdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign wdata   = pwdata[CNT_W-1:0];

  always_comb begin
    sync_quota_nxt  = sync_quota_r;
    batch_limit_nxt = batch_limit_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SYNC_QUOTA:  sync_quota_nxt = wdata;
        // store zero as one
        REG_BATCH_LIMIT: batch_limit_nxt = (wdata == '0) ? CNT_W'(1) : wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_quota_r  <= RESET_SYNC_QUOTA;
      batch_limit_r <= RESET_BATCH_LIMIT;
    end else begin
      sync_quota_r  <= sync_quota_nxt;
      batch_limit_r <= batch_limit_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SYNC_QUOTA:  prdata = CFG_DATA_W'(sync_quota_r);
      REG_BATCH_LIMIT: prdata = CFG_DATA_W'(batch_limit_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.sync_quota  = sync_quota_r;
  assign cfg.batch_limit = batch_limit_r;

endmodule

[sv/sync_async_weighted_dispatcher_top.sv]
// ----------------------------------------------------------------------------
// sync_async_weighted_dispatcher_top
// Two-class weighted round-robin dispatcher over sync and async tag deques.
// ----------------------------------------------------------------------------
//  channel  direction  handshake       payload
//  in_ch    in         valid/ready     action, request_tag, is_sync, at_head
//  out_ch   out        valid/ready     status, out_tag, out_sync
//  cfg_*    in         APB write/read  sync quota @0x0, batch limit @0x4
//
//  Each item has an accept cycle and a result cycle: the accept cycle reads
//  or writes one queue memory entry and updates pointers and counters; the
//  result cycle moves the registered memory read data into the output register.
//  A result that is not taken holds the block in its result cycle.
//  Reset clears pointers, fill counts and counters; no clearing pass runs.
// ----------------------------------------------------------------------------
`include "sync_async_weighted_dispatcher_top_defines.svh"

module sync_async_weighted_dispatcher_top import sawd_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_WIDTH   = DEF_TAG_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sawd_in_if.sink               in_ch,
  sawd_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  state_t state_r, state_nxt;

  cfg_t    cfg;
  q_cmd_t  sync_cmd, async_cmd;
  q_stat_t sync_stat, async_stat;
  res_t    res, pend_r;

  logic [TAG_WIDTH-1:0] wr_tag, sync_rd, async_rd, sel_rd;
  logic [63:0]          in_tag_ext, rd_ext;

  logic                  fire, out_free, load_out;
  logic                  sync_busy, async_busy;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [PORT_TAG_W-1:0] out_tag_r, res_tag;
  logic                  out_sync_r;

  assign fire     = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_tag_ext = 64'(in_ch.request_tag);
  assign wr_tag     = in_tag_ext[TAG_WIDTH-1:0];

  sawd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sawd_sched u_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .action     (in_ch.action),
    .is_sync    (in_ch.is_sync),
    .at_head    (in_ch.at_head),
    .cfg        (cfg),
    .sync_stat  (sync_stat),
    .async_stat (async_stat),
    .sync_cmd   (sync_cmd),
    .async_cmd  (async_cmd),
    .res        (res)
  );

  sawd_queue #(.DEPTH(QUEUE_DEPTH), .TAG_W(TAG_WIDTH)) u_sync_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (sync_cmd),
    .wr_tag (wr_tag),
    .stat   (sync_stat),
    .rd_tag (sync_rd)
  );

  sawd_queue #(.DEPTH(QUEUE_DEPTH), .TAG_W(TAG_WIDTH)) u_async_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (async_cmd),
    .wr_tag (wr_tag),
    .stat   (async_stat),
    .rd_tag (async_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (fire) state_nxt = S_RESULT;
      S_RESULT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_RESULT: load_out = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    sel_rd  = pend_r.from_sync ? sync_rd : async_rd;
    rd_ext  = 64'(sel_rd);
    res_tag = (pend_r.status == ST_DISPATCHED) ? rd_ext[PORT_TAG_W-1:0] : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the decision until the read data lands
  always_ff @(posedge clk) begin
    if (fire) begin
      pend_r <= res;
    end
    if (load_out) begin
      out_status_r <= pend_r.status;
      out_tag_r    <= res_tag;
      out_sync_r   <= pend_r.from_sync && (pend_r.status == ST_DISPATCHED);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.out_tag  = out_tag_r;
  assign out_ch.out_sync = out_sync_r;

  assign sync_busy  = sync_cmd.push || sync_cmd.pop;
  assign async_busy = async_cmd.push || async_cmd.pop;

  `SAWD_ASSERT_NEXT(a_fire_to_result, fire, state_r == S_RESULT, "accept did not enter result")
  `SAWD_ASSERT_NEXT(a_load_valid, load_out, out_valid_r, "loaded result not presented")
  `SAWD_ASSERT_NOW(a_one_queue_op, fire, !(sync_busy && async_busy), "both queues driven")

endmodule
